### rtl/lpfd_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
package lpfd_pkg;

  localparam int unsigned LEN_WIDTH = 32;

  localparam logic [LEN_WIDTH-1:0] MIN_STARTUP_LEN = 32'd8;
  localparam logic [LEN_WIDTH-1:0] MIN_TYPED_LEN   = 32'd4;
  localparam logic [LEN_WIDTH-1:0] LEN_FIELD_BYTES = 32'd4;
  localparam logic [LEN_WIDTH-1:0] MAX_FRAME_RESET = 32'd16777216;

  localparam logic [1:0] HEADER_LAST = 2'd3;
  localparam logic [2:0] CODE_BYTES  = 3'd4;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_LONG  = 2'd2
  } status_t;

  typedef enum logic {
    CFG_STARTUP_MODE = 1'b0,
    CFG_MAX_FRAME    = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]           frame_type;
    logic [7:0]           payload_byte;
    logic                 has_data;
    logic                 last;
    logic [LEN_WIDTH-1:0] startup_code;
    status_t              status;
  } result_t;

endpackage

### rtl/length_prefixed_frame_deframer.sv
// Top level of the length-prefixed frame deframer.
// The deframer takes one link byte per clock cycle and sustains that rate while results are
// taken: each accepted byte is held in an input register, parsed by the header and body
// state machine once the output side has room, and any result is written to a two-entry
// output register that presents it, behind the input register; the only loop is the parser
// state update. Typed frames are a type byte, a big-endian length that counts itself (4 up to
// max_frame_bytes) and the body; startup frames drop the type byte, need a length of at least 8,
// and return the first four body bytes as startup_code on the last result. A bad length yields
// one error result, after which all bytes are accepted and dropped until reset. Configuration
// writes are always ready and must be issued only while no request is in flight; startup_mode is
// sampled when a frame begins.
module length_prefixed_frame_deframer (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_type,
  output logic [7:0]  payload_byte,
  output logic        has_data,
  output logic        last,
  output logic [31:0] startup_code,
  output logic [1:0]  status,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic                           startup_mode;
  logic [lpfd_pkg::LEN_WIDTH-1:0] max_frame_bytes;

  logic              hold_valid;
  logic [7:0]        hold_byte;
  logic              advance;
  logic              parse_valid;
  logic              skid_ready;
  lpfd_pkg::result_t parse_result;
  lpfd_pkg::result_t out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      startup_mode    <= 1'b0;
      max_frame_bytes <= lpfd_pkg::MAX_FRAME_RESET;
    end else if (cfg_valid) begin
      case (lpfd_pkg::cfg_index_t'(cfg_index))
        lpfd_pkg::CFG_STARTUP_MODE: startup_mode    <= cfg_data[0];
        lpfd_pkg::CFG_MAX_FRAME:    max_frame_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // A held byte moves on only when the output side has room for a possible result.
  assign advance  = hold_valid && skid_ready;
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= in_byte;
    end
  end

  lpfd_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .data_byte       (hold_byte),
    .startup_mode    (startup_mode),
    .max_frame_bytes (max_frame_bytes),
    .result_valid    (parse_valid),
    .result          (parse_result)
  );

  lpfd_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (parse_valid),
    .push_data  (parse_result),
    .push_ready (skid_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_result)
  );

  assign frame_type   = out_result.frame_type;
  assign payload_byte = out_result.payload_byte;
  assign has_data     = out_result.has_data;
  assign last         = out_result.last;
  assign startup_code = out_result.startup_code;
  assign status       = out_result.status;

endmodule

### rtl/lpfd_parser.sv
// Frame header and body parser: consumes one byte per advance, emits at most one result.
module lpfd_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [7:0]                    data_byte,
  input  logic                          startup_mode,
  input  logic [lpfd_pkg::LEN_WIDTH-1:0] max_frame_bytes,
  output logic                          result_valid,
  output lpfd_pkg::result_t             result
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN_TYPED,
    PH_LEN_START,
    PH_BODY_TYPED,
    PH_BODY_START,
    PH_HALT
  } phase_t;

  phase_t                         phase, phase_next;
  logic [1:0]                     header_count, header_count_next;
  logic [lpfd_pkg::LEN_WIDTH-1:0] length_shift, length_shift_next;
  logic [lpfd_pkg::LEN_WIDTH-1:0] bytes_left, bytes_left_next;
  logic [7:0]                     type_hold, type_hold_next;
  logic [lpfd_pkg::LEN_WIDTH-1:0] code_shift, code_shift_next;
  logic [2:0]                     code_count, code_count_next;

  logic [lpfd_pkg::LEN_WIDTH-1:0] len_assembled;
  logic [lpfd_pkg::LEN_WIDTH-1:0] min_len;
  logic                           is_startup;

  assign len_assembled = {length_shift[lpfd_pkg::LEN_WIDTH-9:0], data_byte};
  assign is_startup    = (phase == PH_LEN_START) || (phase == PH_BODY_START);
  assign min_len       = is_startup ? lpfd_pkg::MIN_STARTUP_LEN : lpfd_pkg::MIN_TYPED_LEN;

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    length_shift_next = length_shift;
    bytes_left_next   = bytes_left;
    type_hold_next    = type_hold;
    code_shift_next   = code_shift;
    code_count_next   = code_count;

    result_valid        = 1'b0;
    result.frame_type   = is_startup ? 8'd0 : type_hold;
    result.payload_byte = 8'd0;
    result.has_data     = 1'b0;
    result.last         = 1'b1;
    result.startup_code = '0;
    result.status       = lpfd_pkg::STATUS_OK;

    case (phase)
      PH_IDLE: begin
        code_shift_next = '0;
        code_count_next = '0;
        if (startup_mode) begin
          type_hold_next    = 8'd0;
          length_shift_next = {{(lpfd_pkg::LEN_WIDTH-8){1'b0}}, data_byte};
          header_count_next = 2'd1;
          phase_next        = PH_LEN_START;
        end else begin
          type_hold_next    = data_byte;
          length_shift_next = '0;
          header_count_next = 2'd0;
          phase_next        = PH_LEN_TYPED;
        end
      end
      PH_LEN_TYPED, PH_LEN_START: begin
        length_shift_next = len_assembled;
        if (header_count != lpfd_pkg::HEADER_LAST) begin
          header_count_next = header_count + 2'd1;
        end else begin
          header_count_next = 2'd0;
          bytes_left_next   = len_assembled - lpfd_pkg::LEN_FIELD_BYTES;
          // The minimum test wins over the maximum test.
          if (len_assembled < min_len) begin
            phase_next    = PH_HALT;
            result_valid  = 1'b1;
            result.status = lpfd_pkg::STATUS_SHORT;
          end else if (len_assembled > max_frame_bytes) begin
            phase_next    = PH_HALT;
            result_valid  = 1'b1;
            result.status = lpfd_pkg::STATUS_LONG;
          end else if (len_assembled == lpfd_pkg::LEN_FIELD_BYTES) begin
            phase_next   = PH_IDLE;
            result_valid = 1'b1;
          end else begin
            phase_next = is_startup ? PH_BODY_START : PH_BODY_TYPED;
          end
        end
      end
      PH_BODY_TYPED, PH_BODY_START: begin
        if (is_startup && (code_count < lpfd_pkg::CODE_BYTES)) begin
          code_shift_next = {code_shift[lpfd_pkg::LEN_WIDTH-9:0], data_byte};
          code_count_next = code_count + 3'd1;
        end
        bytes_left_next     = bytes_left - {{(lpfd_pkg::LEN_WIDTH-1){1'b0}}, 1'b1};
        result_valid        = 1'b1;
        result.payload_byte = data_byte;
        result.has_data     = 1'b1;
        result.last         = (bytes_left == {{(lpfd_pkg::LEN_WIDTH-1){1'b0}}, 1'b1});
        if (result.last) begin
          phase_next = PH_IDLE;
          if (is_startup) begin
            result.startup_code = code_shift_next;
          end
        end
      end
      default: begin
        // Halted after a bad length: bytes are dropped until reset.
        phase_next = PH_HALT;
      end
    endcase

    if (!advance) begin
      result_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      header_count <= '0;
      length_shift <= '0;
      bytes_left   <= '0;
      type_hold    <= '0;
      code_shift   <= '0;
      code_count   <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      length_shift <= length_shift_next;
      bytes_left   <= bytes_left_next;
      type_hold    <= type_hold_next;
      code_shift   <= code_shift_next;
      code_count   <= code_count_next;
    end
  end

endmodule

### rtl/lpfd_skid.sv
// Two-entry output register with skid slot so results flow at full rate under backpressure.
module lpfd_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lpfd_pkg::result_t push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lpfd_pkg::result_t out_data
);

  logic              spare_valid;
  lpfd_pkg::result_t spare_data;

  assign push_ready = !spare_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (spare_valid) begin
        out_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= spare_valid ? spare_data : push_data;
    end else if (push) begin
      spare_data <= push_data;
    end
  end

endmodule

### bench/length_prefixed_frame_deframer_test.sv
// Self-checking testbench for the length-prefixed frame deframer.
module length_prefixed_frame_deframer_test;

  localparam int CLK_PERIOD    = 12;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ROUNDS = 9;
  localparam int ROUND_BYTES   = 150;
  localparam int SHOWN_ERRORS  = 10;

  typedef enum logic [2:0] {
    WAIT_FRAME,
    TYPED_LEN,
    STARTUP_LEN,
    TYPED_BODY,
    STARTUP_BODY,
    HALTED
  } deframe_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  frame_type;
  logic [7:0]  payload_byte;
  logic        has_data;
  logic        last;
  logic [31:0] startup_code;
  logic [1:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = 32'd0;

  // Expected deframer state and register copies.
  deframe_state_t parse_state = WAIT_FRAME;
  logic [1:0]  hdr_count = 2'd0;
  logic [31:0] len_acc = 32'd0;
  logic [31:0] remaining = 32'd0;
  logic [7:0]  held_type = 8'd0;
  logic [31:0] code_acc = 32'd0;
  logic [2:0]  code_seen = 3'd0;
  logic        mode_startup = 1'b0;
  logic [31:0] max_len = lpfd_pkg::MAX_FRAME_RESET;

  logic [7:0]        link_bytes[$];
  lpfd_pkg::result_t awaited_results[$];
  int bytes_queued = 0;
  int bytes_accepted = 0;
  int error_count = 0;
  int send_idle_pct = 22;
  int recv_stall_pct = 61;

  // A header left half sent at the end of a round, finished in the next one.
  logic       carry_open = 1'b0;
  logic       carry_startup = 1'b0;
  logic [7:0] carry_kind = 8'd0;
  int         carry_skip = 0;

  length_prefixed_frame_deframer u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_type  (frame_type),
    .payload_byte(payload_byte),
    .has_data    (has_data),
    .last        (last),
    .startup_code(startup_code),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void await_result(input lpfd_pkg::result_t r);
    awaited_results = {awaited_results, r};
  endfunction

  task automatic parse_link_byte(input logic [7:0] b);
    lpfd_pkg::result_t r;
    logic in_startup;
    logic [31:0] floor_len;
    r = '0;
    case (parse_state)
      WAIT_FRAME: begin
        code_acc = 32'd0;
        code_seen = 3'd0;
        len_acc = 32'd0;
        if (mode_startup) begin
          held_type = 8'd0;
          len_acc = {24'd0, b};
          hdr_count = 2'd1;
          parse_state = STARTUP_LEN;
        end else begin
          held_type = b;
          hdr_count = 2'd0;
          parse_state = TYPED_LEN;
        end
      end
      TYPED_LEN, STARTUP_LEN: begin
        in_startup = (parse_state == STARTUP_LEN);
        floor_len = in_startup ? lpfd_pkg::MIN_STARTUP_LEN : lpfd_pkg::MIN_TYPED_LEN;
        len_acc = {len_acc[23:0], b};
        if (hdr_count < lpfd_pkg::HEADER_LAST) begin
          hdr_count = hdr_count + 2'd1;
        end else begin
          hdr_count = 2'd0;
          r.frame_type = in_startup ? 8'd0 : held_type;
          r.last = 1'b1;
          // The minimum is checked first, so a short length never reports as long.
          if (len_acc < floor_len) begin
            parse_state = HALTED;
            r.status = lpfd_pkg::STATUS_SHORT;
            await_result(r);
          end else if (len_acc > max_len) begin
            parse_state = HALTED;
            r.status = lpfd_pkg::STATUS_LONG;
            await_result(r);
          end else begin
            remaining = len_acc - lpfd_pkg::LEN_FIELD_BYTES;
            if (remaining == 32'd0) begin
              parse_state = WAIT_FRAME;
              r.status = lpfd_pkg::STATUS_OK;
              await_result(r);
            end else begin
              parse_state = in_startup ? STARTUP_BODY : TYPED_BODY;
            end
          end
        end
      end
      TYPED_BODY, STARTUP_BODY: begin
        in_startup = (parse_state == STARTUP_BODY);
        if (in_startup && code_seen < lpfd_pkg::CODE_BYTES) begin
          code_acc = {code_acc[23:0], b};
          code_seen = code_seen + 3'd1;
        end
        remaining = remaining - 32'd1;
        r.frame_type = in_startup ? 8'd0 : held_type;
        r.payload_byte = b;
        r.has_data = 1'b1;
        r.status = lpfd_pkg::STATUS_OK;
        if (remaining == 32'd0) begin
          r.last = 1'b1;
          if (in_startup) r.startup_code = code_acc;
          parse_state = WAIT_FRAME;
        end
        await_result(r);
      end
      default: begin
      end
    endcase
  endtask

  function automatic string describe(input lpfd_pkg::result_t r);
    return $sformatf("type %02h byte %02h data %0b last %0b code %08h status %0d",
                     r.frame_type, r.payload_byte, r.has_data, r.last, r.startup_code,
                     r.status);
  endfunction

  function automatic void push_link_byte(input logic [7:0] b);
    link_bytes = {link_bytes, b};
    bytes_queued++;
  endfunction

  // Header bytes in wire order; startup frames have no type byte.
  function automatic void queue_header(input logic startup, input logic [7:0] kind,
                                       input logic [31:0] length, input int from,
                                       input int upto);
    logic [7:0] hdr[5];
    int base;
    base = startup ? 1 : 0;
    hdr[0] = kind;
    hdr[1] = length[31:24];
    hdr[2] = length[23:16];
    hdr[3] = length[15:8];
    hdr[4] = length[7:0];
    for (int i = from; i < upto; i++) push_link_byte(hdr[i + base]);
  endfunction

  // A negative fill gives random body bytes.
  function automatic void queue_frame(input logic startup, input logic [7:0] kind,
                                      input logic [31:0] length, input int fill,
                                      input int skip);
    queue_header(startup, kind, length, skip, startup ? 4 : 5);
    for (int i = 4; i < length; i++) push_link_byte(fill < 0 ? 8'($urandom) : 8'(fill));
  endfunction

  // Only high length bytes are sent early, and they are zero for the short frames used here.
  function automatic void open_frame(input logic startup, input logic [7:0] kind,
                                     input int skip);
    carry_startup = startup;
    carry_kind = kind;
    carry_skip = skip;
    carry_open = 1'b1;
    queue_header(startup, kind, 32'd0, 0, skip);
  endfunction

  function automatic void close_frame(input logic [31:0] length);
    queue_frame(carry_startup, carry_kind, length, -1, carry_skip);
    carry_open = 1'b0;
  endfunction

  function automatic logic [31:0] pick_length(input logic startup);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = startup ? lpfd_pkg::MIN_STARTUP_LEN : lpfd_pkg::MIN_TYPED_LEN;
    hi = lo + (($urandom_range(15) == 0) ? 32'd100 : 32'd20);
    if (hi > max_len) hi = max_len;
    case ($urandom_range(7))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  task automatic write_reg(input lpfd_pkg::cfg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lpfd_pkg::CFG_STARTUP_MODE) mode_startup = value[0];
    else max_len = value;
  endtask

  // Bytes that complete no frame give no result, so the wait ends with an extra settle period.
  task automatic wait_quiet();
    do @(posedge clk);
    while (bytes_accepted != bytes_queued || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        bytes_accepted++;
        parse_link_byte(in_byte);
      end
      if (!in_valid || in_ready) begin
        if (link_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_byte <= link_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    lpfd_pkg::result_t got;
    lpfd_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      got.frame_type = frame_type;
      got.payload_byte = payload_byte;
      got.has_data = has_data;
      got.last = last;
      got.startup_code = startup_code;
      got.status = lpfd_pkg::status_t'(status);
      if (awaited_results.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_ERRORS) $display("result with none expected: %s", describe(got));
      end else begin
        want = awaited_results.pop_front();
        if (got.frame_type !== want.frame_type || got.payload_byte !== want.payload_byte ||
            got.has_data !== want.has_data || got.last !== want.last ||
            got.startup_code !== want.startup_code || got.status !== want.status) begin
          error_count++;
          if (error_count <= SHOWN_ERRORS)
            $display("mismatch: expected %s, got %s", describe(want), describe(got));
        end
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [31:0] cap;
    logic [31:0] bad_len;
    int mark;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Typed frames under the reset limit, then a header cut off after two length bytes.
    @(negedge clk);
    queue_frame(1'b0, 8'h00, 32'd4, -1, 0);
    queue_frame(1'b0, 8'hFF, 32'd5, 8'hFF, 0);
    queue_frame(1'b0, 8'hA5, 32'd6, 8'h00, 0);
    open_frame(1'b0, 8'h3C, 3);
    wait_quiet();

    // The open frame stays typed after the switch to startup mode.
    write_reg(lpfd_pkg::CFG_STARTUP_MODE, 32'd1);
    write_reg(lpfd_pkg::CFG_MAX_FRAME, 32'd8);
    @(negedge clk);
    close_frame(32'd7);
    queue_frame(1'b1, 8'h00, 32'd8, 8'hFF, 0);
    queue_frame(1'b1, 8'h00, 32'd8, 8'h00, 0);
    wait_quiet();

    write_reg(lpfd_pkg::CFG_MAX_FRAME, 32'hFFFF_FFFF);
    @(negedge clk);
    queue_frame(1'b1, 8'h00, 32'd9, -1, 0);
    queue_frame(1'b1, 8'h00, 32'd12, -1, 0);
    wait_quiet();

    write_reg(lpfd_pkg::CFG_STARTUP_MODE, 32'd0);
    write_reg(lpfd_pkg::CFG_MAX_FRAME, 32'd8);
    @(negedge clk);
    queue_frame(1'b0, 8'h5A, 32'd8, -1, 0);
    queue_frame(1'b0, 8'h01, 32'd4, -1, 0);
    wait_quiet();

    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      write_reg(lpfd_pkg::CFG_STARTUP_MODE, 32'($urandom_range(1)));
      case ($urandom_range(4))
        0: cap = 32'd8;
        1: cap = 32'hFFFF_FFFF;
        2: cap = lpfd_pkg::MAX_FRAME_RESET;
        default: cap = $urandom_range(40, 8);
      endcase
      write_reg(lpfd_pkg::CFG_MAX_FRAME, cap);
      @(negedge clk);
      case (round / 3)
        0: begin
          send_idle_pct = 22;
          recv_stall_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_stall_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      mark = bytes_queued;
      if (carry_open) close_frame(pick_length(carry_startup));
      while (bytes_queued - mark < ROUND_BYTES)
        queue_frame(mode_startup, 8'($urandom), pick_length(mode_startup), -1, 0);
      if (round < RANDOM_ROUNDS - 1 && $urandom_range(2) == 0)
        open_frame(mode_startup, 8'($urandom),
                   mode_startup ? $urandom_range(3, 1) : $urandom_range(4, 1));
      wait_quiet();
    end

    // A bad length halts the block for good, so it comes last and the bytes after it are dropped.
    case ($urandom_range(2))
      0: begin
        write_reg(lpfd_pkg::CFG_STARTUP_MODE, 32'd0);
        bad_len = $urandom_range(3);
      end
      1: begin
        write_reg(lpfd_pkg::CFG_STARTUP_MODE, 32'd1);
        bad_len = $urandom_range(7);
      end
      default: begin
        write_reg(lpfd_pkg::CFG_STARTUP_MODE, 32'($urandom_range(1)));
        cap = ($urandom_range(1) == 0) ? 32'($urandom_range(40, 8)) : 32'hFFFF_FFFE;
        write_reg(lpfd_pkg::CFG_MAX_FRAME, cap);
        bad_len = $urandom;
        if ($urandom_range(1) == 0 || bad_len <= cap) bad_len = cap + 32'd1;
      end
    endcase
    @(negedge clk);
    queue_header(mode_startup, 8'($urandom), bad_len, 0, mode_startup ? 4 : 5);
    repeat (24) push_link_byte(8'($urandom));
    wait_quiet();

    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
